[rtl/complex_halfband_decimator_defines.svh]
// Assertion macros for the RTL of the complex halfband decimator.
`ifndef COMPLEX_HALFBAND_DECIMATOR_DEFINES_SVH
`define COMPLEX_HALFBAND_DECIMATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define CHD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("complex_halfband_decimator: assertion failed");
`define CHD_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("complex_halfband_decimator: assertion failed");
`else
`define CHD_ASSERT(label, clk, rst, prop)
`define CHD_ASSERT_NORST(label, clk, prop)
`endif
`endif

[rtl/chd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package chd_pkg;

  localparam int MAX_TAPS    = 28;
  localparam int TAP_WORDS   = 7;
  localparam int TAPS_PER_WD = 4;
  localparam int TAP_W       = 16;
  localparam int SAMPLE_W    = 16;
  localparam int TAP_IDX_W   = $clog2(MAX_TAPS);
  localparam int CNT_W       = $clog2(MAX_TAPS + 1);
  localparam int TAP_COUNT_W = 5;
  localparam int TAP_WORD_W  = 64;
  localparam int REG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int Q_SHIFT     = 15;
  localparam int PROD_W      = SAMPLE_W + TAP_W;
  localparam int ACC_W       = PROD_W + $clog2(MAX_TAPS) + 1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TAP_COUNT,
    REG_TAP_WORD_0,
    REG_TAP_WORD_1,
    REG_TAP_WORD_2,
    REG_TAP_WORD_3,
    REG_TAP_WORD_4,
    REG_TAP_WORD_5,
    REG_TAP_WORD_6
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_q;
    logic signed [SAMPLE_W-1:0] sample_i;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] result_q;
    logic signed [SAMPLE_W-1:0] result_i;
  } result_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
  } mac_ctrl_t;

endpackage
`default_nettype wire

[rtl/chd_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
module chd_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              write_en,
  input  wire logic [chd_pkg::REG_IDX_W-1:0]     reg_index,
  input  wire logic [chd_pkg::CFG_DATA_W-1:0]    write_data,
  input  wire logic [chd_pkg::TAP_IDX_W-1:0]     tap_idx,
  output logic signed [chd_pkg::TAP_W-1:0]       tap,
  output logic [chd_pkg::CNT_W-1:0]              n_taps
);
  import chd_pkg::*;

  logic [TAP_COUNT_W-1:0] tap_count;
  logic [TAP_WORD_W-1:0]  tap_word [TAP_WORDS];
  logic [REG_IDX_W-1:0]   word_sel;

  assign word_sel = reg_index - REG_IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_W'(1);
      for (int w = 0; w < TAP_WORDS; w++) begin
        tap_word[w] <= '0;
      end
    end else if (write_en) begin
      if (reg_index == REG_TAP_COUNT) begin
        tap_count <= write_data[TAP_COUNT_W-1:0];
      end else begin
        tap_word[word_sel] <= write_data[TAP_WORD_W-1:0];
      end
    end
  end

  // Tap k lives in word k/4, lane k%4; only indexes below MAX_TAPS are used.
  assign tap = $signed(tap_word[tap_idx[TAP_IDX_W-1:2]][TAP_W*tap_idx[1:0] +: TAP_W]);

  assign n_taps = (tap_count > TAP_COUNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : CNT_W'(tap_count);

endmodule
`default_nettype wire

[rtl/chd_window.sv]
`timescale 1ns / 1ps
`default_nettype none
module chd_window (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           shift_en,
  input  wire chd_pkg::sample_t               din,
  input  wire logic [chd_pkg::TAP_IDX_W-1:0]  rd_addr,
  output chd_pkg::sample_t                    rd_data
);
  import chd_pkg::*;

  sample_t win [MAX_TAPS];

  // Oldest sample at entry zero, newest at the top entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_TAPS; k++) begin
        win[k] <= '0;
      end
    end else if (shift_en) begin
      for (int k = 0; k < MAX_TAPS - 1; k++) begin
        win[k] <= win[k+1];
      end
      win[MAX_TAPS-1] <= din;
    end
  end

  assign rd_data = win[rd_addr];

endmodule
`default_nettype wire

[rtl/chd_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
module chd_mac (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire chd_pkg::mac_ctrl_t             ctrl,
  input  wire chd_pkg::sample_t               sample,
  input  wire logic signed [chd_pkg::TAP_W-1:0] tap,
  output chd_pkg::result_t                    sat
);
  import chd_pkg::*;

  localparam int SH_W = ACC_W - Q_SHIFT;
  localparam logic signed [SH_W-1:0] SatHi = SH_W'(32767);
  localparam logic signed [SH_W-1:0] SatLo = -SH_W'(32768);

  logic signed [PROD_W-1:0] prod_i;
  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_valid;
  logic signed [ACC_W-1:0]  acc_i;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [SH_W-1:0]   sh_i;
  logic signed [SH_W-1:0]   sh_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_i <= sample.sample_i * tap;
      prod_q <= sample.sample_q * tap;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_i <= '0;
      acc_q <= '0;
    end else if (prod_valid) begin
      acc_i <= acc_i + {{(ACC_W-PROD_W){prod_i[PROD_W-1]}}, prod_i};
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  // Arithmetic shift floors the Q15 sum before saturation.
  assign sh_i = SH_W'(acc_i >>> Q_SHIFT);
  assign sh_q = SH_W'(acc_q >>> Q_SHIFT);

  always_comb begin
    if (sh_i > SatHi) begin
      sat.result_i = SAMPLE_W'(SatHi);
    end else if (sh_i < SatLo) begin
      sat.result_i = SAMPLE_W'(SatLo);
    end else begin
      sat.result_i = sh_i[SAMPLE_W-1:0];
    end
    if (sh_q > SatHi) begin
      sat.result_q = SAMPLE_W'(SatHi);
    end else if (sh_q < SatLo) begin
      sat.result_q = SAMPLE_W'(SatLo);
    end else begin
      sat.result_q = sh_q[SAMPLE_W-1:0];
    end
  end

endmodule
`default_nettype wire

[rtl/complex_halfband_decimator.sv]
// Complex halfband decimator by two. Each item carries one signed 16-bit I/Q
// sample into a 28-deep delay line; every second item produces one result item,
// the Q15 FIR sum over the newest tap_count samples (oldest takes tap 0), floored
// by 2^15 and saturated to 16 bits. An item that produces no result is taken
// without a stall. An item that produces a result holds sample_stall high
// through the MAC, DRAIN and FIN states, with tap_count held at no more than 28:
// one MAC pass per tap through a single shared multiply-accumulate pair (I and
// Q side by side), DRAIN to drain the product register, and FIN to saturate into
// the output register. FIN repeats while an earlier result still waits in the
// output register under result_stall. A finished result waits in the output
// register while the next item is accepted. The user must see that configuration
// is written only while the block is idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
`include "complex_halfband_decimator_defines.svh"
module complex_halfband_decimator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            write_en,
  input  wire logic [chd_pkg::REG_IDX_W-1:0]   reg_index,
  input  wire logic [chd_pkg::CFG_DATA_W-1:0]  write_data,
  input  wire logic                            sample_valid,
  output logic                                 sample_stall,
  input  wire chd_pkg::sample_t                sample,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output chd_pkg::result_t                     result
);
  import chd_pkg::*;

  state_t                 state;
  state_t                 state_next;
  logic                   phase;
  logic [TAP_IDX_W-1:0]   tap_idx;
  logic [TAP_IDX_W-1:0]   tap_idx_next;
  logic                   sample_acc;
  logic                   out_free;
  logic                   load_out;
  logic                   last_tap;
  logic [CNT_W-1:0]       n_taps;
  logic [TAP_IDX_W-1:0]   win_addr;
  logic signed [TAP_W-1:0] tap;
  sample_t                win_data;
  result_t                sat;
  mac_ctrl_t              mac_ctrl;

  assign sample_acc = sample_valid && !sample_stall;
  assign out_free   = !result_valid || !result_stall;
  assign last_tap   = (CNT_W'(tap_idx) == n_taps - CNT_W'(1));
  assign win_addr   = TAP_IDX_W'(CNT_W'(MAX_TAPS) - n_taps + CNT_W'(tap_idx));

  chd_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .write_en   (write_en),
    .reg_index  (reg_index),
    .write_data (write_data),
    .tap_idx    (tap_idx),
    .tap        (tap),
    .n_taps     (n_taps)
  );

  chd_window u_window (
    .clk      (clk),
    .rst      (rst),
    .shift_en (sample_acc),
    .din      (sample),
    .rd_addr  (win_addr),
    .rd_data  (win_data)
  );

  chd_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .sample (win_data),
    .tap    (tap),
    .sat    (sat)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample_acc && phase) begin
          state_next = (n_taps == '0) ? ST_DRAIN : ST_MAC;
        end
      end
      ST_MAC: begin
        if (last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    sample_stall    = 1'b1;
    mac_ctrl.clear  = 1'b0;
    mac_ctrl.mul_en = 1'b0;
    load_out        = 1'b0;
    tap_idx_next    = tap_idx;
    unique case (state)
      ST_IDLE: begin
        sample_stall   = 1'b0;
        mac_ctrl.clear = 1'b1;
        tap_idx_next   = '0;
      end
      ST_MAC: begin
        mac_ctrl.mul_en = 1'b1;
        tap_idx_next    = tap_idx + TAP_IDX_W'(1);
      end
      ST_DRAIN: begin
      end
      ST_FIN: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= 1'b0;
      tap_idx      <= '0;
      result_valid <= 1'b0;
    end else begin
      state   <= state_next;
      tap_idx <= tap_idx_next;
      if (sample_acc) begin
        phase <= !phase;
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result <= sat;
    end
  end

  `CHD_ASSERT(a_even_item_no_work, clk, rst, (sample_acc && !phase) |=> state == ST_IDLE)
  `CHD_ASSERT(a_odd_item_starts, clk, rst, (sample_acc && phase) |=> (state == ST_MAC || state == ST_DRAIN))
  `CHD_ASSERT(a_tap_idx_in_range, clk, rst, (state == ST_MAC) |-> (CNT_W'(tap_idx) < n_taps))
  `CHD_ASSERT(a_result_from_fin, clk, rst, $rose(result_valid) |-> $past(state) == ST_FIN)
  `CHD_ASSERT_NORST(a_reset_idle, clk, rst |=> (state == ST_IDLE && !result_valid))

endmodule
`default_nettype wire

[verif/tb_complex_halfband_decimator.sv]
`timescale 1ns / 1ps
module tb_complex_halfband_decimator;
  import chd_pkg::*;

  localparam int RUN_LIMIT  = 500000;
  localparam int SETTLE     = 40;
  localparam int RAND_SETS  = 12;
  localparam int SET_ITEMS  = 70;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  write_en = 1'b0;
  logic [REG_IDX_W-1:0]  reg_index = '0;
  logic [CFG_DATA_W-1:0] write_data = '0;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  sample_t               sample = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;

  complex_halfband_decimator dut (
    .clk(clk),
    .rst(rst),
    .write_en(write_en),
    .reg_index(reg_index),
    .write_data(write_data),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always #5 clk = ~clk;

  // Shadow copy of the filter state and registers.
  logic [4:0]            shadow_tap_count = 5'd1;
  logic [TAP_WORD_W-1:0] shadow_coef [TAP_WORDS];
  sample_t               shadow_window [MAX_TAPS];
  logic                  shadow_phase = 1'b0;

  sample_t pending_samples [$];
  result_t due_results [$];
  int      queued_count = 0;
  int      accepted_count = 0;
  int      error_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      cycle_count = 0;
  result_t want;

  initial begin
    for (int w = 0; w < TAP_WORDS; w++) shadow_coef[w] = '0;
    for (int k = 0; k < MAX_TAPS; k++) shadow_window[k] = '0;
  end

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Floor of the Q15 dot product over the newest taps, saturated per part.
  function automatic result_t fir_output();
    int                 n;
    longint             acc_i;
    longint             acc_q;
    logic signed [15:0] coef;
    sample_t            s;
    result_t            r;
    n = (shadow_tap_count > MAX_TAPS) ? MAX_TAPS : int'(shadow_tap_count);
    acc_i = 0;
    acc_q = 0;
    for (int k = 0; k < n; k++) begin
      coef = shadow_coef[k / 4][16 * (k % 4) +: 16];
      s = shadow_window[MAX_TAPS - n + k];
      acc_i += longint'($signed(s.sample_i)) * longint'(coef);
      acc_q += longint'($signed(s.sample_q)) * longint'(coef);
    end
    r.result_i = clip16(acc_i >>> Q_SHIFT);
    r.result_q = clip16(acc_q >>> Q_SHIFT);
    return r;
  endfunction

  task automatic shift_in_sample(sample_t s);
    for (int k = 0; k + 1 < MAX_TAPS; k++) shadow_window[k] = shadow_window[k + 1];
    shadow_window[MAX_TAPS - 1] = s;
    if (shadow_phase) due_results.push_back(fir_output());
    shadow_phase = ~shadow_phase;
  endtask

  // Sender: a presented item stays unchanged until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        accepted_count++;
        shift_in_sample(sample);
      end
      if (!sample_valid || !sample_stall) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          sample <= pending_samples.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (due_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result item i=%0d q=%0d", $time,
                 result.result_i, result.result_q);
      end else begin
        want = due_results.pop_front();
        if (result.result_i !== want.result_i) begin
          error_count++;
          $display("%0t: result_i expected %0d actual %0d", $time,
                   want.result_i, result.result_i);
        end
        if (result.result_q !== want.result_q) begin
          error_count++;
          $display("%0t: result_q expected %0d actual %0d", $time,
                   want.result_q, result.result_q);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("tb_complex_halfband_decimator: FAIL");
      $finish;
    end
  end

  // Each call drives one write; the caller lowers write_en after the last one.
  task automatic cfg_write(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    write_en <= 1'b1;
    reg_index <= idx;
    write_data <= data;
    if (idx == REG_TAP_COUNT) shadow_tap_count = data[4:0];
    else shadow_coef[int'(idx) - 1] = data;
  endtask

  task automatic cfg_done();
    @(posedge clk);
    write_en <= 1'b0;
  endtask

  task automatic set_all_taps(logic [15:0] coef);
    for (int w = 0; w < TAP_WORDS; w++)
      cfg_write(reg_index_t'(REG_TAP_WORD_0 + w), {4{coef}});
  endtask

  task automatic queue_sample(logic [15:0] si, logic [15:0] sq);
    sample_t s;
    s.sample_i = si;
    s.sample_q = sq;
    pending_samples.push_back(s);
    queued_count++;
  endtask

  // Waits until every item is taken and every result has come back.
  task automatic drain();
    while (accepted_count != queued_count || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return {16{1'($urandom_range(1))}};
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset registers: one tap of zero, so results are zero.
    queue_sample(16'h7FFF, 16'h8000);
    queue_sample(16'hFFFF, 16'h0001);
    drain();

    // Full length with every tap at -1.0; most of the window is still empty.
    cfg_write(REG_TAP_COUNT, 28);
    set_all_taps(16'h8000);
    cfg_done();
    repeat (6) queue_sample(16'h8000, 16'h8000);
    queue_sample(16'h7FFF, 16'h7FFF);
    queue_sample(16'h7FFF, 16'h8000);
    queue_sample(16'h0000, 16'h8000);
    drain();

    // No taps in use.
    cfg_write(REG_TAP_COUNT, 0);
    cfg_done();
    queue_sample(16'h7FFF, 16'h8000);
    queue_sample(16'h8000, 16'h7FFF);
    drain();

    // A count above the window length is held at the window length.
    cfg_write(REG_TAP_COUNT, 31);
    set_all_taps(16'h7FFF);
    cfg_done();
    for (int k = 0; k < 6; k++) queue_sample(k[0] ? 16'h8000 : 16'h7FFF, 16'h8000);
    drain();

    for (int p = 0; p < RAND_SETS; p++) begin
      case ($urandom_range(7))
        0: cfg_write(REG_TAP_COUNT, 0);
        1: cfg_write(REG_TAP_COUNT, 1);
        2: cfg_write(REG_TAP_COUNT, 28);
        3: cfg_write(REG_TAP_COUNT, $urandom_range(31, 29));
        default: cfg_write(REG_TAP_COUNT, $urandom_range(28, 1));
      endcase
      case ($urandom_range(3))
        0: set_all_taps($urandom_range(1) ? 16'h8000 : 16'h7FFF);
        default: begin
          for (int w = 0; w < TAP_WORDS; w++)
            cfg_write(reg_index_t'(REG_TAP_WORD_0 + w), {$urandom, $urandom});
        end
      endcase
      cfg_done();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      repeat (SET_ITEMS) queue_sample(pick_value(), pick_value());
      drain();
    end

    if (due_results.size() != 0) begin
      error_count++;
      $display("%0t: %0d result items never arrived", $time, due_results.size());
    end
    if (error_count == 0) begin
      $display("tb_complex_halfband_decimator: PASS");
    end else begin
      $display("tb_complex_halfband_decimator: FAIL");
    end
    $finish;
  end

endmodule
